>>> design/cpf_pkg.sv
// ----------------------------------------------------------------------------
// cpf_pkg - shared types and constants for the closest pair finder
// Command word passed from the front end to the back end, field widths,
// metric codes and status codes.
// ----------------------------------------------------------------------------
package cpf_pkg;

    // field widths
    localparam int COORD_W    = 16;
    localparam int IDX_W      = 8;
    localparam int DIST_W     = 33;
    localparam int BEST_W     = 34;
    localparam int STATUS_W   = 2;
    localparam int MODE_W     = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;

    // command queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CNT_W = 3;

    // metric codes
    localparam logic [MODE_W-1:0] MODE_DX     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DY     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SQ_EUC = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_FEW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

    // one classified point
    typedef struct packed {
        logic                      last;
        logic                      store;
        logic [COORD_W-1:0]        y;
        logic [COORD_W-1:0]        x;
    } t_cmd;

endpackage

>>> design/closest_pair_finder_unit.sv
// ----------------------------------------------------------------------------
// closest_pair_finder_unit - streaming closest pair of points
// Takes a set of points and reports the closest pair and its distance under
// the selected metric once the last point of the set has arrived.
//
//   channel  dir  signals                     contents
//   s_       in   s_tvalid/s_tready/s_tdata   point x [15:0], y [31:16]
//                 s_tlast                     last point of the set
//   m_       out  m_tvalid/m_tready/m_tdata   first, second, distance, status
//   cfg      in   i_cfg_valid/o_cfg_ready     metric mode, 2 bits
//
// A point that finds points already held is compared in the back end with one
// store read per held point through a four stage distance pipe, plus drain
// and write-back, and only then takes the next point from the queue.
// The front end classifies points and runs ahead by up to four queued points.
// Reset is synchronous, active low; the store needs no clearing pass.
// A stalled result holds the back end only on the last point of the next set.
// ----------------------------------------------------------------------------
module closest_pair_finder_unit
    import cpf_pkg::*;
#(
    parameter int MAX_POINTS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // point input, tdata: point_x [15:0], point_y [31:16]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    // result, tdata: first_index [7:0], second_index [15:8],
    // pair_distance [48:16], status [50:49]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    // metric mode register
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [MODE_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int QW = $bits(t_cmd) + CW;

    logic [MODE_W-1:0] r_metric_mode;
    logic              w_push;
    logic              w_pop;
    logic              w_q_full;
    logic              w_q_valid;
    t_cmd              w_front_cmd;
    logic [CW-1:0]     w_front_count;
    logic [QW-1:0]     w_q_out;
    t_cmd              w_back_cmd;
    logic [CW-1:0]     w_back_count;

    // metric register, writable at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric_mode <= MODE_SQ_EUC;
        end else if (i_cfg_valid) begin
            r_metric_mode <= i_cfg_data;
        end
    end

    // front end
    cpf_front #(
        .MAX_POINTS (MAX_POINTS),
        .CW         (CW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .o_ready  (s_tready),
        .i_data   (s_tdata),
        .i_last   (s_tlast),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_front_cmd),
        .o_count  (w_front_count)
    );

    // command queue
    cpf_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_front_count, w_front_cmd}),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_out)
    );

    assign w_back_cmd   = w_q_out[$bits(t_cmd)-1:0];
    assign w_back_count = w_q_out[QW-1:$bits(t_cmd)];

    // back end
    cpf_back #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW),
        .CW         (CW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_cmd         (w_back_cmd),
        .i_count       (w_back_count),
        .o_q_pop       (w_pop),
        .i_metric_mode (r_metric_mode),
        .o_m_valid     (m_tvalid),
        .i_m_ready     (m_tready),
        .o_m_data      (m_tdata)
    );

endmodule

>>> design/cpf_front.sv
// ----------------------------------------------------------------------------
// cpf_front - input stage of the closest pair finder
// Accepts points, numbers them within the set and marks those over capacity.
// ----------------------------------------------------------------------------
module cpf_front
    import cpf_pkg::*;
#(
    parameter int MAX_POINTS = 256,
    parameter int CW         = $clog2(MAX_POINTS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [IN_DATA_W-1:0] i_data,
    input  logic                 i_last,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_cmd                 o_cmd,
    output logic [CW-1:0]        o_count
);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          w_store;

    // room left in the point store
    assign w_store = (r_count < CW'(MAX_POINTS));

    // transfer whenever the queue has space
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    assign o_cmd.x     = i_data[COORD_W-1:0];
    assign o_cmd.y     = i_data[2*COORD_W-1:COORD_W];
    assign o_cmd.last  = i_last;
    assign o_cmd.store = w_store;
    assign o_count     = r_count;

    // points held in the current set
    always_comb begin
        n_count = r_count;
        if (o_push) begin
            if (i_last) begin
                n_count = '0;
            end else if (w_store) begin
                n_count = r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

>>> design/cpf_queue.sv
// ----------------------------------------------------------------------------
// cpf_queue - short command queue between front and back end
// Four-entry first-in first-out buffer with registered storage.
// ----------------------------------------------------------------------------
module cpf_queue
    import cpf_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0]       r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wr;
    logic [Q_AW-1:0]    r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + Q_AW'(1);
            if (w_pop)  r_rd <= r_rd + Q_AW'(1);
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_data;
    end

endmodule

>>> design/cpf_back.sv
// ----------------------------------------------------------------------------
// cpf_back - compare engine of the closest pair finder
// Scans the stored points against each new one through a pipelined distance
// unit, keeps the best pair and emits the set result.
// ----------------------------------------------------------------------------
module cpf_back
    import cpf_pkg::*;
#(
    parameter int MAX_POINTS = 256,
    parameter int AW         = $clog2(MAX_POINTS),
    parameter int CW         = $clog2(MAX_POINTS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_cmd                  i_cmd,
    input  logic [CW-1:0]         i_count,
    output logic                  o_q_pop,
    input  logic [MODE_W-1:0]     i_metric_mode,
    output logic                  o_m_valid,
    input  logic                  i_m_ready,
    output logic [OUT_DATA_W-1:0] o_m_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [AW-1:0] r_scan;
    logic          w_issue;
    logic [CW-1:0] w_last_j;
    logic [AW-1:0] w_last_scan;

    // point store
    logic [COORD_W-1:0] r_x_mem [MAX_POINTS];
    logic [COORD_W-1:0] r_y_mem [MAX_POINTS];

    // pipeline
    logic                 r_v1, r_v2, r_v3, r_v4;
    logic [AW-1:0]        r_j1, r_j2, r_j3, r_j4;
    logic [COORD_W-1:0]   r_rd_x, r_rd_y;
    logic [COORD_W-1:0]   r_dx, r_dy;
    logic [COORD_W-1:0]   r_dx3, r_dy3;
    logic [2*COORD_W-1:0] r_sqx, r_sqy;
    logic [DIST_W-1:0]    r_dist4;
    logic signed [COORD_W:0] w_diff_x, w_diff_y;
    logic [DIST_W-1:0]    w_metric;
    logic                 w_busy;

    // best pair of the set
    logic [BEST_W-1:0] r_best;
    logic [AW-1:0]     r_best_first;
    logic [AW-1:0]     r_best_second;
    logic              r_dropped;

    // result register
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic                  w_out_free;
    logic                  w_finish;
    logic [CW-1:0]         w_held;
    logic [STATUS_W-1:0]   w_status;
    logic [IDX_W-1:0]      w_first;
    logic [IDX_W-1:0]      w_second;
    logic [DIST_W-1:0]     w_dist;

    assign w_last_j    = i_count - CW'(1);
    assign w_last_scan = w_last_j[AW-1:0];
    assign w_issue     = (r_state == ST_SCAN);
    assign w_busy      = r_v1 || r_v2 || r_v3 || r_v4;
    assign w_out_free  = !r_m_valid || i_m_ready;
    assign w_finish    = (r_state == ST_DONE) && (!i_cmd.last || w_out_free);
    assign o_q_pop     = w_finish;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_cmd.store && (i_count != '0)) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (r_scan == w_last_scan) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!w_busy) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_finish) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_scan  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_scan <= '0;
            end else if (w_issue) begin
                r_scan <= r_scan + AW'(1);
            end
        end
    end

    // store read and write
    always_ff @(posedge i_clk) begin
        r_rd_x <= r_x_mem[r_scan];
        r_rd_y <= r_y_mem[r_scan];
        if (w_finish && i_cmd.store) begin
            r_x_mem[i_count[AW-1:0]] <= i_cmd.x;
            r_y_mem[i_count[AW-1:0]] <= i_cmd.y;
        end
    end

    // coordinate gaps
    assign w_diff_x = $signed({r_rd_x[COORD_W-1], r_rd_x})
                    - $signed({i_cmd.x[COORD_W-1], i_cmd.x});
    assign w_diff_y = $signed({r_rd_y[COORD_W-1], r_rd_y})
                    - $signed({i_cmd.y[COORD_W-1], i_cmd.y});

    // metric selection
    always_comb begin
        case (i_metric_mode)
            MODE_DX: w_metric = DIST_W'(r_dx3);
            MODE_DY: w_metric = DIST_W'(r_dy3);
            default: w_metric = DIST_W'(r_sqx) + DIST_W'(r_sqy);
        endcase
    end

    // distance pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // distance pipeline data
    always_ff @(posedge i_clk) begin
        r_j1    <= r_scan;
        r_j2    <= r_j1;
        r_dx    <= w_diff_x[COORD_W] ? COORD_W'(-w_diff_x) : w_diff_x[COORD_W-1:0];
        r_dy    <= w_diff_y[COORD_W] ? COORD_W'(-w_diff_y) : w_diff_y[COORD_W-1:0];
        r_j3    <= r_j2;
        r_dx3   <= r_dx;
        r_dy3   <= r_dy;
        r_sqx   <= r_dx * r_dx;
        r_sqy   <= r_dy * r_dy;
        r_j4    <= r_j3;
        r_dist4 <= w_metric;
    end

    // best pair tracking, cleared at end of set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best        <= '1;
            r_best_first  <= '0;
            r_best_second <= '0;
            r_dropped     <= 1'b0;
        end else if (w_finish && i_cmd.last) begin
            r_best        <= '1;
            r_best_first  <= '0;
            r_best_second <= '0;
            r_dropped     <= 1'b0;
        end else begin
            if (r_v4 && ({1'b0, r_dist4} < r_best)) begin
                r_best        <= {1'b0, r_dist4};
                r_best_first  <= r_j4;
                r_best_second <= i_count[AW-1:0];
            end
            if (w_finish && !i_cmd.store) r_dropped <= 1'b1;
        end
    end

    // set result
    assign w_held = i_count + CW'(i_cmd.store);

    always_comb begin
        if (w_held < CW'(2)) begin
            w_status = STATUS_TOO_FEW;
            w_first  = '0;
            w_second = '0;
            w_dist   = '0;
        end else begin
            w_status = (r_dropped || !i_cmd.store) ? STATUS_DROPPED : STATUS_OK;
            w_first  = IDX_W'(r_best_first);
            w_second = IDX_W'(r_best_second);
            w_dist   = r_best[DIST_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_finish && i_cmd.last) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish && i_cmd.last) begin
            r_m_data <= {5'b0, w_status, w_dist, w_second, w_first};
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_m_data  = r_m_data;

endmodule

>>> verif/tb_closest_pair_finder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_closest_pair_finder_unit - self-checking bench for the closest pair finder
// Streams sets of points into the unit under random sender bursts and receiver
// stalls. An in-bench copy of the set state predicts every report at the point
// transfer that ends a set. Each report is checked field by field, in order.
// Directed sets come first, then random sets: small sets, clustered and
// duplicated points, one full set, one set over capacity, and metric changes
// both between sets and inside a set.
// ----------------------------------------------------------------------------
module tb_closest_pair_finder_unit;
    import cpf_pkg::*;

    localparam int CAPACITY      = 256;
    localparam int TOTAL_POINTS  = 1450;
    localparam int SETTLE_CYCLES = 1400;
    localparam longint LIMIT_NS  = 64'd8_000_000;

    // spare metric code, handled as squared euclidean
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam logic signed [COORD_W-1:0] COORD_MIN = -16'sd32768;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sd32767;

    // point content styles for random sets
    localparam int STYLE_SPREAD  = 0;
    localparam int STYLE_CLUSTER = 1;
    localparam int STYLE_CORNERS = 2;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } t_point_item;

    // result word, fields from the highest bit down
    typedef struct packed {
        logic [OUT_DATA_W-2*IDX_W-DIST_W-STATUS_W-1:0] fill;
        logic [STATUS_W-1:0]                           status;
        logic [DIST_W-1:0]                             pair_dist;
        logic [IDX_W-1:0]                              second_idx;
        logic [IDX_W-1:0]                              first_idx;
    } t_pair_report;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata     = '0;
    logic                  s_tlast     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [MODE_W-1:0]     i_cfg_data  = '0;

    // pending points and predicted reports
    t_point_item  point_queue[$];
    t_pair_report predicted_reports[$];
    int           queued_count   = 0;
    int           accepted_count = 0;
    int           mismatch_count = 0;

    // shadow of the set state and the metric register
    logic signed [COORD_W-1:0] held_x [CAPACITY];
    logic signed [COORD_W-1:0] held_y [CAPACITY];
    int                        held_count    = 0;
    logic [BEST_W-1:0]         best_dist     = '1;
    logic [IDX_W-1:0]          best_lo       = '0;
    logic [IDX_W-1:0]          best_hi       = '0;
    bit                        overflow_seen = 1'b0;
    logic [MODE_W-1:0]         metric_shadow = MODE_SQ_EUC;

    // sender and receiver pacing
    int           burst_left = 1;
    int           gap_left   = 0;
    int           rx_left    = 0;
    int           rx_style   = 0;
    int           rx_tick    = 0;
    bit           rx_ready_next;
    t_point_item  next_pt;
    t_pair_report seen;
    t_pair_report want;

    closest_pair_finder_unit #(
        .MAX_POINTS (CAPACITY)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // point_x [15:0], point_y [31:16]
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),     // first [7:0], second [15:8], dist [48:16], status [50:49]
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // pair distance under the current metric
    function automatic logic [BEST_W-1:0] metric_of(logic signed [COORD_W-1:0] xa,
                                                    logic signed [COORD_W-1:0] ya,
                                                    logic signed [COORD_W-1:0] xb,
                                                    logic signed [COORD_W-1:0] yb);
        longint dx;
        longint dy;
        dx = longint'(xa) - longint'(xb);
        dy = longint'(ya) - longint'(yb);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        case (metric_shadow)
            MODE_DX: return BEST_W'(dx);
            MODE_DY: return BEST_W'(dy);
            default: return BEST_W'(dx * dx + dy * dy);
        endcase
    endfunction

    // compare a new point with all held points, report on the last point
    function automatic void absorb_point(logic signed [COORD_W-1:0] x,
                                         logic signed [COORD_W-1:0] y,
                                         logic last);
        logic [BEST_W-1:0] d;
        t_pair_report      r;
        if (held_count < CAPACITY) begin
            for (int j = 0; j < held_count; j++) begin
                d = metric_of(held_x[j], held_y[j], x, y);
                // strict compare keeps the earlier pair on a tie
                if (d < best_dist) begin
                    best_dist = d;
                    best_lo   = IDX_W'(j);
                    best_hi   = IDX_W'(held_count);
                end
            end
            held_x[held_count] = x;
            held_y[held_count] = y;
            held_count++;
        end else begin
            overflow_seen = 1'b1;
        end
        if (last) begin
            r = '0;
            if (held_count < 2) begin
                r.status = STATUS_TOO_FEW;
            end else begin
                r.first_idx  = best_lo;
                r.second_idx = best_hi;
                r.pair_dist  = best_dist[DIST_W-1:0];
                r.status     = overflow_seen ? STATUS_DROPPED : STATUS_OK;
            end
            predicted_reports.push_back(r);
            held_count    = 0;
            best_dist     = '1;
            best_lo       = '0;
            best_hi       = '0;
            overflow_seen = 1'b0;
        end
    endfunction

    // point sender, bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_point(s_tdata[COORD_W-1:0], s_tdata[2*COORD_W-1:COORD_W], s_tlast);
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || point_queue.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_tvalid <= 1'b0;
                end else begin
                    next_pt = point_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_pt.y, next_pt.x};
                    s_tlast  <= next_pt.last;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // report receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen = m_tdata;
                if (predicted_reports.size() == 0) begin
                    $error("report transfer with no prediction pending: %h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = predicted_reports.pop_front();
                    if (seen.first_idx !== want.first_idx) begin
                        $error("first_index: expected %0d, got %0d",
                               want.first_idx, seen.first_idx);
                        mismatch_count++;
                    end
                    if (seen.second_idx !== want.second_idx) begin
                        $error("second_index: expected %0d, got %0d",
                               want.second_idx, seen.second_idx);
                        mismatch_count++;
                    end
                    if (seen.pair_dist !== want.pair_dist) begin
                        $error("pair_distance: expected %0d, got %0d",
                               want.pair_dist, seen.pair_dist);
                        mismatch_count++;
                    end
                    if (seen.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, seen.status);
                        mismatch_count++;
                    end
                end
            end
            // stall pattern is redrawn each time its random hold runs out
            if (rx_left == 0) begin
                rx_style = $urandom_range(0, 3);
                rx_left  = $urandom_range(20, 200);
            end else begin
                rx_left--;
            end
            rx_tick++;
            case (rx_style)
                0:       rx_ready_next = 1'b1;
                1:       rx_ready_next = (rx_tick % 3) != 0;
                2:       rx_ready_next = 1'($urandom_range(0, 1));
                default: rx_ready_next = (rx_tick % 16) >= 12;
            endcase
            m_tready <= rx_ready_next;
        end
    end

    function automatic void push_point(logic signed [COORD_W-1:0] x,
                                       logic signed [COORD_W-1:0] y,
                                       logic last);
        point_queue.push_back('{x: x, y: y, last: last});
        queued_count++;
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord(int style,
                                                            logic signed [COORD_W-1:0] center);
        logic signed [COORD_W-1:0] v;
        v = COORD_W'($urandom);
        if (style == STYLE_CLUSTER) begin
            v = center + COORD_W'($urandom_range(0, 31));
        end else if (style == STYLE_CORNERS) begin
            case ($urandom_range(0, 3))
                0:       v = COORD_MIN;
                1:       v = COORD_MAX;
                2:       v = '0;
                default: v = COORD_W'($urandom);
            endcase
        end
        return v;
    endfunction

    // wait until every point is taken and every report is back, then drain
    task automatic settle();
        @(posedge i_clk);
        while (accepted_count != queued_count || predicted_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_metric(logic [MODE_W-1:0] code);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= code;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        metric_shadow = code;
        i_cfg_valid <= 1'b0;
    endtask

    // one random set, optionally with a metric change part way through
    task automatic queue_set(int count, bit split);
        t_point_item               pts[$];
        t_point_item               p;
        int                        style;
        int                        cut;
        int                        src;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        style = $urandom_range(STYLE_SPREAD, STYLE_CORNERS);
        cx    = COORD_W'($urandom);
        cy    = COORD_W'($urandom);
        for (int i = 0; i < count; i++) begin
            // duplicates force ties; the top slot repeats its neighbor
            if (i == CAPACITY - 1 || (i > 0 && $urandom_range(0, 7) == 0)) begin
                src = (i == CAPACITY - 1) ? i - 1 : $urandom_range(0, i - 1);
                p   = pts[src];
            end else begin
                p.x = pick_coord(style, cx);
                p.y = pick_coord(style, cy);
            end
            p.last = (i == count - 1);
            pts.push_back(p);
        end
        cut = split ? $urandom_range(1, count - 2) : count;
        for (int i = 0; i < count; i++) begin
            if (i == cut) write_metric(MODE_W'($urandom_range(0, 3)));
            push_point(pts[i].x, pts[i].y, pts[i].last);
        end
    endtask

    // stimulus
    initial begin
        int  size;
        int  roll;
        bit  full_done;
        bit  over_done;
        full_done = 1'b0;
        over_done = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single point set, too few points
        push_point(0, 0, 1'b1);
        // opposite corners, largest squared distance
        push_point(COORD_MIN, COORD_MIN, 1'b0);
        push_point(COORD_MAX, COORD_MAX, 1'b1);
        // equal distances, the first pair found stays
        push_point(0, 0, 1'b0);
        push_point(3, 4, 1'b0);
        push_point(6, 8, 1'b1);

        write_metric(MODE_DX);
        push_point(100, -5, 1'b0);
        push_point(-100, 7, 1'b0);
        push_point(101, 30000, 1'b1);

        write_metric(MODE_DY);
        push_point(5, COORD_MAX, 1'b0);
        push_point(-9, COORD_MIN, 1'b0);
        push_point(0, 32760, 1'b1);

        // spare code behaves as squared euclidean
        write_metric(MODE_SPARE);
        push_point(1, 1, 1'b0);
        push_point(1, 1, 1'b1);

        // metric switched inside a set
        write_metric(MODE_SQ_EUC);
        push_point(0, 0, 1'b0);
        push_point(10, 0, 1'b0);
        write_metric(MODE_DY);
        push_point(50, 3, 1'b1);

        // random sets, mostly small, one full and one over capacity
        while (queued_count < TOTAL_POINTS) begin
            if ($urandom_range(0, 5) == 0) write_metric(MODE_W'($urandom_range(0, 3)));
            roll = $urandom_range(0, 99);
            if (!full_done && queued_count > 400) begin
                size      = CAPACITY;
                full_done = 1'b1;
            end else if (!over_done && queued_count > 950) begin
                size      = CAPACITY + $urandom_range(1, 6);
                over_done = 1'b1;
            end else if (roll < 6) begin
                size = 1;
            end else if (roll < 88) begin
                size = $urandom_range(2, 10);
            end else begin
                size = $urandom_range(11, 40);
            end
            queue_set(size, size >= 3 && $urandom_range(0, 11) == 0);
        end

        settle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // run limit
    initial begin
        #(LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule
